[hw/rtl/greedy_word_wrap_assert.svh]
// Assertion macros shared by the greedy word wrap RTL.
// Each file that checks its own logic includes this header; it needs clk and rst_n in scope.
`ifndef GREEDY_WORD_WRAP_ASSERT_SVH
`define GREEDY_WORD_WRAP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define GWW_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define GWW_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gww_pkg.sv]
// Shared types and constants for the greedy word wrap block.
// Used by every RTL module of the block; depends on nothing else.
package gww_pkg;

    localparam int POS_W      = 13;
    localparam int WID_W      = 20;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WID_W;
    localparam int ROWS_MAX   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_TEXT_DEF = 4096;

    localparam logic [WID_W-1:0] TEXT_WIDTH_RST = WID_W'(640);

    // Character kinds; any other code is handled as a regular character.
    localparam logic [1:0] KIND_REGULAR = 2'd0;
    localparam logic [1:0] KIND_SPACE   = 2'd1;
    localparam logic [1:0] KIND_NEWLINE = 2'd2;

    // Why a row was closed.
    localparam logic [1:0] REASON_NEWLINE  = 2'd0;
    localparam logic [1:0] REASON_SPACE    = 2'd1;
    localparam logic [1:0] REASON_OVERFULL = 2'd2;
    localparam logic [1:0] REASON_FINAL    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RESTRICT_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_WIDTH     = 1'd1;

    typedef struct packed {
        logic [1:0]        char_kind;
        logic [CHAR_W-1:0] char_width;
        logic              last_char;
    } char_item_t;

    typedef struct packed {
        logic [POS_W-1:0] row_begin;
        logic [POS_W-1:0] row_end;
        logic [1:0]       row_reason;
        logic             run_end;
    } row_item_t;

    typedef struct packed {
        logic             restrict_width;
        logic [WID_W-1:0] text_width;
    } cfg_t;

    // Rows produced by one character, in order; count says how many are meaningful.
    typedef struct packed {
        logic [1:0]                    count;
        row_item_t [ROWS_MAX-1:0]      rows;
    } row_batch_t;

endpackage

[hw/rtl/gww_cfg.sv]
// Configuration registers of the greedy word wrap block.
// Depends on gww_pkg for the register indexes and the cfg_t type.
module gww_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [gww_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gww_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gww_pkg::cfg_t                   cfg
);

    gww_pkg::cfg_t cfg_reg;
    gww_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                gww_pkg::REG_RESTRICT_WIDTH: cfg_next.restrict_width = cfg_data[0];
                gww_pkg::REG_TEXT_WIDTH:     cfg_next.text_width = cfg_data[gww_pkg::WID_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.restrict_width <= 1'b0;
            cfg_reg.text_width     <= gww_pkg::TEXT_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/gww_core.sv]
// Input register, line breaking state and the single-pass break decision.
// Depends on gww_pkg; checks itself with the macros of greedy_word_wrap_assert.svh.
`include "greedy_word_wrap_assert.svh"

module gww_core #(
    parameter int MAX_TEXT = gww_pkg::MAX_TEXT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  gww_pkg::char_item_t        char_item,
    input  gww_pkg::cfg_t              cfg,
    input  logic [2:0]                 queue_space,
    output logic                       go,
    output gww_pkg::row_batch_t        batch
);

    localparam int PW    = $clog2(MAX_TEXT);
    localparam int PosW  = gww_pkg::POS_W;
    localparam int WidW  = gww_pkg::WID_W;
    localparam logic [PW:0] MaxPos = (PW+1)'(MAX_TEXT);

    logic                  full_reg;
    logic                  full_next;
    gww_pkg::char_item_t   item_reg;

    logic [PW-1:0]         position_reg, position_next;
    logic [PW:0]           row_start_reg, row_start_next;
    logic [PW-1:0]         last_space_pos_reg, last_space_pos_next;
    logic                  space_seen_reg, space_seen_next;
    logic [WidW-1:0]       safe_width_reg, safe_width_next;
    logic [WidW-1:0]       chunk_width_reg, chunk_width_next;
    logic [gww_pkg::CHAR_W-1:0] last_space_width_reg, last_space_width_next;

    logic [PW:0]           pos_inc;
    logic [PW:0]           space_inc;
    logic [WidW-1:0]       chunk_add;
    logic [WidW-1:0]       chunk_cut;
    logic [WidW-1:0]       space_w_ext;
    logic                  over_limit;
    logic [1:0]            cnt;
    gww_pkg::row_batch_t   batch_c;

    function automatic logic [WidW-1:0] sat_add(input logic [WidW-1:0] a,
                                                input logic [WidW-1:0] b);
        logic [WidW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[WidW] ? {WidW{1'b1}} : s[WidW-1:0];
        end
    endfunction

    function automatic gww_pkg::row_item_t make_row(input logic [PW:0] b,
                                                    input logic [PW:0] e,
                                                    input logic [1:0]  why);
        gww_pkg::row_item_t r;
        begin
            r.row_begin  = PosW'(b);
            r.row_end    = PosW'(e);
            r.row_reason = why;
            r.run_end    = 1'b0;
            make_row     = r;
        end
    endfunction

    always_comb
    begin
        pos_inc     = {1'b0, position_reg} + (PW+1)'(1);
        space_inc   = {1'b0, last_space_pos_reg} + (PW+1)'(1);
        chunk_add   = sat_add(chunk_width_reg, WidW'(item_reg.char_width));
        space_w_ext = WidW'(last_space_width_reg);
        chunk_cut   = (chunk_add >= space_w_ext) ? (chunk_add - space_w_ext) : '0;
        over_limit  = cfg.restrict_width &&
                      (({1'b0, chunk_add} + {1'b0, safe_width_reg}) >
                       {1'b0, cfg.text_width});

        position_next         = position_reg;
        row_start_next        = row_start_reg;
        last_space_pos_next   = last_space_pos_reg;
        space_seen_next       = space_seen_reg;
        safe_width_next       = safe_width_reg;
        chunk_width_next      = chunk_width_reg;
        last_space_width_next = last_space_width_reg;
        batch_c               = '0;
        cnt                   = 2'd0;

        case (item_reg.char_kind)
            gww_pkg::KIND_SPACE:
            begin
                safe_width_next       = sat_add(safe_width_reg, chunk_width_reg);
                last_space_pos_next   = position_reg;
                space_seen_next       = 1'b1;
                last_space_width_next = item_reg.char_width;
                chunk_width_next      = WidW'(item_reg.char_width);
            end
            gww_pkg::KIND_NEWLINE:
            begin
                batch_c.rows[cnt] = make_row(row_start_reg, pos_inc, gww_pkg::REASON_NEWLINE);
                cnt               = cnt + 2'd1;
                row_start_next    = pos_inc;
                space_seen_next   = 1'b0;
                chunk_width_next  = '0;
                safe_width_next   = '0;
            end
            default:
            begin
                chunk_width_next = chunk_add;
                if (over_limit)
                begin
                    safe_width_next = '0;
                    if (space_seen_reg)
                    begin
                        // Cut at the last space; the chunk after it may still be too wide.
                        batch_c.rows[cnt] = make_row(row_start_reg, {1'b0, last_space_pos_reg},
                                                     gww_pkg::REASON_SPACE);
                        cnt             = cnt + 2'd1;
                        space_seen_next = 1'b0;
                        row_start_next  = space_inc;
                        chunk_width_next = chunk_cut;
                        if (chunk_cut > cfg.text_width)
                        begin
                            batch_c.rows[cnt] = make_row(space_inc, pos_inc,
                                                         gww_pkg::REASON_OVERFULL);
                            cnt              = cnt + 2'd1;
                            row_start_next   = pos_inc;
                            chunk_width_next = '0;
                        end
                    end
                    else
                    begin
                        batch_c.rows[cnt] = make_row(row_start_reg, pos_inc,
                                                     gww_pkg::REASON_OVERFULL);
                        cnt              = cnt + 2'd1;
                        row_start_next   = pos_inc;
                        chunk_width_next = '0;
                    end
                end
            end
        endcase

        if (item_reg.last_char)
        begin
            batch_c.rows[cnt]     = make_row(row_start_next, pos_inc, gww_pkg::REASON_FINAL);
            cnt                   = cnt + 2'd1;
            position_next         = '0;
            row_start_next        = '0;
            last_space_pos_next   = '0;
            space_seen_next       = 1'b0;
            safe_width_next       = '0;
            chunk_width_next      = '0;
            last_space_width_next = '0;
        end
        else if (pos_inc < MaxPos)
        begin
            position_next = pos_inc[PW-1:0];
        end

        if (cnt != 2'd0)
        begin
            batch_c.rows[cnt - 2'd1].run_end = 1'b1;
        end
        batch_c.count = cnt;
    end

    // The held character is processed once all of its rows fit in the row queue.
    assign go         = full_reg && ({1'b0, batch_c.count} <= queue_space);
    assign char_stall = full_reg && !go;
    assign batch      = batch_c;

    always_comb
    begin
        full_next = full_reg;
        if (char_valid && !char_stall)
        begin
            full_next = 1'b1;
        end
        else if (go)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            item_reg <= char_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg             <= 1'b0;
            position_reg         <= '0;
            row_start_reg        <= '0;
            last_space_pos_reg   <= '0;
            space_seen_reg       <= 1'b0;
            safe_width_reg       <= '0;
            chunk_width_reg      <= '0;
            last_space_width_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
            if (go)
            begin
                position_reg         <= position_next;
                row_start_reg        <= row_start_next;
                last_space_pos_reg   <= last_space_pos_next;
                space_seen_reg       <= space_seen_next;
                safe_width_reg       <= safe_width_next;
                chunk_width_reg      <= chunk_width_next;
                last_space_width_reg <= last_space_width_next;
            end
        end
    end

    `GWW_CHECK(row_start_bounded, row_start_reg <= pos_inc, "row start ran ahead of position")
    `GWW_CHECK_NEXT(position_advances, go && !item_reg.last_char, position_reg != '0,
                    "position did not advance after a character")
    `GWW_CHECK_NEXT(text_cleared, go && item_reg.last_char,
                    row_start_reg == '0 && !space_seen_reg && chunk_width_reg == '0,
                    "state not cleared after the last character")

endmodule

[hw/rtl/gww_row_queue.sv]
// Small shifting queue that holds finished rows until the receiver takes them.
// Depends on gww_pkg; checks itself with the macros of greedy_word_wrap_assert.svh.
`include "greedy_word_wrap_assert.svh"

module gww_row_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  gww_pkg::row_batch_t    batch,
    output logic [2:0]             space,
    output logic                   row_valid,
    input  logic                   row_stall,
    output gww_pkg::row_item_t     row_item
);

    localparam int Depth = gww_pkg::QUEUE_DEPTH;
    localparam int CntW  = 3;

    gww_pkg::row_item_t [Depth-1:0] q_reg;
    gww_pkg::row_item_t [Depth-1:0] q_next;
    gww_pkg::row_item_t [Depth-1:0] q_cur;
    logic [CntW-1:0]                count_reg;
    logic [CntW-1:0]                count_next;
    logic [CntW-1:0]                base;
    logic [CntW-1:0]                off;
    logic                           pop;

    always_comb
    begin
        pop   = (count_reg != '0) && !row_stall;
        base  = count_reg - CntW'(pop);
        q_cur = pop ? (q_reg >> $bits(gww_pkg::row_item_t)) : q_reg;
        q_next = q_cur;
        off    = '0;
        for (int k = 0; k < Depth; k++)
        begin
            off = CntW'(k) - base;
            if (push && (CntW'(k) >= base) && (off < CntW'(batch.count)))
            begin
                q_next[k] = batch.rows[off[1:0]];
            end
        end
        count_next = push ? (base + CntW'(batch.count)) : base;
        space      = CntW'(Depth) - base;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign row_valid = (count_reg != '0);
    assign row_item  = q_reg[0];

    `GWW_CHECK(count_in_range, count_reg <= CntW'(Depth), "row queue count out of range")
    `GWW_CHECK(no_overflow, !push || (CntW'(batch.count) <= space),
               "rows pushed without room in the queue")

endmodule

[hw/rtl/greedy_word_wrap.sv]
// Greedy word wrap row breaker: turns a character stream into row spans.
// Top level; instantiates gww_cfg, gww_core and gww_row_queue, types from gww_pkg.
//
// Characters enter on the char channel (char_valid, char_stall, char_item) and row
// spans leave on the row channel (row_valid, row_stall, row_item). An item moves
// when valid is high and stall is low at a rising edge of clk.
// An accepted character is held in an input register; once the queue has room for its
// rows, the break decision is made in one pass and zero to three rows are pushed into a
// four-entry row queue, whose head drives row_item. The rows of a character are thus
// registered in the queue before the first of them is offered on row_item.
// One character is accepted every cycle while the queue has room for its rows. The
// row side drains one row per cycle while row_stall is low, so the sustained rate
// is one character per cycle, less when characters close rows faster than the
// receiver takes them. When the receiver stalls, the queue fills and char_stall rises
// for any character whose rows do not fit; characters that close no row still pass.
// rst_n clears the queue, the input register and the line state, sets restrict_width
// to 0 and text_width to 640. Configuration is written through cfg_write_en,
// cfg_index and cfg_data, and should only change while no item is in flight.
module greedy_word_wrap #(
    parameter int MAX_TEXT = gww_pkg::MAX_TEXT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            char_valid,
    output logic                            char_stall,
    input  gww_pkg::char_item_t             char_item,
    output logic                            row_valid,
    input  logic                            row_stall,
    output gww_pkg::row_item_t              row_item,
    input  logic                            cfg_write_en,
    input  logic [gww_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gww_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gww_pkg::cfg_t        cfg;
    gww_pkg::row_batch_t  batch;
    logic                 go;
    logic [2:0]           queue_space;

    gww_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    gww_core #(
        .MAX_TEXT (MAX_TEXT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_item   (char_item),
        .cfg         (cfg),
        .queue_space (queue_space),
        .go          (go),
        .batch       (batch)
    );

    gww_row_queue u_row_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (go),
        .batch     (batch),
        .space     (queue_space),
        .row_valid (row_valid),
        .row_stall (row_stall),
        .row_item  (row_item)
    );

endmodule

[tb/tb.sv]
// Testbench for greedy_word_wrap: characters in, row spans out, checked against a predictor.
// Depends on gww_pkg for the item types, codes and widths, and on the RTL top level.
`timescale 1ns / 1ps

// Predicts the rows of each accepted character and checks the rows that come out.
class row_span_book;
    localparam int unsigned WIDTH_MAX = (1 << gww_pkg::WID_W) - 1;

    gww_pkg::row_item_t expected_rows[$];
    int errors;

    bit restrict_on;
    int unsigned limit_w;

    int unsigned pos;
    int unsigned row_start;
    int unsigned space_pos;
    bit space_seen;
    int unsigned safe_w;
    int unsigned chunk_w;
    int unsigned space_w;

    function new();
        restrict_on = 1'b0;
        limit_w = gww_pkg::TEXT_WIDTH_RST;
        errors = 0;
        clear_text();
    endfunction

    function void clear_text();
        pos = 0;
        row_start = 0;
        space_pos = 0;
        space_seen = 1'b0;
        safe_w = 0;
        chunk_w = 0;
        space_w = 0;
    endfunction

    function void set_config(bit r, int unsigned tw);
        restrict_on = r;
        limit_w = tw & WIDTH_MAX;
    endfunction

    function int unsigned sat(int unsigned a);
        return (a > WIDTH_MAX) ? WIDTH_MAX : a;
    endfunction

    function void add_row(int unsigned b, int unsigned e, logic [1:0] why);
        gww_pkg::row_item_t r;
        r.row_begin = gww_pkg::POS_W'(b);
        r.row_end = gww_pkg::POS_W'(e);
        r.row_reason = why;
        r.run_end = 1'b0;
        expected_rows.push_back(r);
    endfunction

    function int pending();
        return expected_rows.size();
    endfunction

    function void note_char(gww_pkg::char_item_t c);
        int unsigned here;
        int unsigned w;
        int base;
        here = pos;
        w = c.char_width;
        base = expected_rows.size();
        if (c.char_kind == gww_pkg::KIND_SPACE)
        begin
            safe_w = sat(safe_w + chunk_w);
            space_pos = here;
            space_seen = 1'b1;
            space_w = w;
            chunk_w = w;
        end
        else if (c.char_kind == gww_pkg::KIND_NEWLINE)
        begin
            add_row(row_start, here + 1, gww_pkg::REASON_NEWLINE);
            row_start = here + 1;
            space_seen = 1'b0;
            chunk_w = 0;
            safe_w = 0;
        end
        else
        begin
            chunk_w = sat(chunk_w + w);
            // Both sums stay below 2^21, so the comparison is exact.
            if (restrict_on && chunk_w + safe_w > limit_w)
            begin
                if (space_seen)
                begin
                    add_row(row_start, space_pos, gww_pkg::REASON_SPACE);
                    row_start = space_pos + 1;
                    space_seen = 1'b0;
                    chunk_w = (chunk_w >= space_w) ? chunk_w - space_w : 0;
                    safe_w = 0;
                    if (chunk_w > limit_w)
                    begin
                        add_row(row_start, here + 1, gww_pkg::REASON_OVERFULL);
                        row_start = here + 1;
                        chunk_w = 0;
                    end
                end
                else
                begin
                    add_row(row_start, here + 1, gww_pkg::REASON_OVERFULL);
                    row_start = here + 1;
                    chunk_w = 0;
                    safe_w = 0;
                end
            end
        end
        if (c.last_char)
        begin
            add_row(row_start, here + 1, gww_pkg::REASON_FINAL);
            clear_text();
        end
        else if (here + 1 < gww_pkg::MAX_TEXT_DEF)
        begin
            pos = here + 1;
        end
        if (expected_rows.size() > base)
            expected_rows[expected_rows.size() - 1].run_end = 1'b1;
    endfunction

    function void check_row(gww_pkg::row_item_t got);
        gww_pkg::row_item_t want;
        if (expected_rows.size() == 0)
        begin
            $error("row %0d..%0d arrived with no row expected", got.row_begin, got.row_end);
            errors++;
            return;
        end
        want = expected_rows.pop_front();
        if (got.row_begin !== want.row_begin)
        begin
            $error("row_begin: expected %0d, got %0d", want.row_begin, got.row_begin);
            errors++;
        end
        if (got.row_end !== want.row_end)
        begin
            $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
            errors++;
        end
        if (got.row_reason !== want.row_reason)
        begin
            $error("row_reason: expected %0d, got %0d", want.row_reason, got.row_reason);
            errors++;
        end
        if (got.run_end !== want.run_end)
        begin
            $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam int unsigned WIDTH_MAX = (1 << gww_pkg::WID_W) - 1;
    localparam int LONG_TEXT = 10;
    localparam int PHASE_ITEMS = 46;
    localparam int LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic char_valid = 1'b0;
    logic char_stall;
    gww_pkg::char_item_t char_item = '0;
    logic row_valid;
    logic row_stall = 1'b0;
    gww_pkg::row_item_t row_item;
    logic cfg_write_en = 1'b0;
    logic [gww_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gww_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    row_span_book book;
    bit quick_gaps = 1'b0;
    int cycles = 0;

    greedy_word_wrap DUT (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_item(char_item),
        .row_valid(row_valid),
        .row_stall(row_stall),
        .row_item(row_item),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && row_valid && !row_stall)
            book.check_row(row_item);
    end

    // Receiver back-pressure: ready stretches, some of them long, broken by stalls.
    initial
    begin
        int ready_len;
        int stall_len;
        int r;
        wait (rst_n === 1'b1);
        forever
        begin
            ready_len = (($urandom % 10) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            row_stall <= 1'b0;
            repeat (ready_len) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 80)
                stall_len = $urandom_range(0, 3);
            else if (r < 95)
                stall_len = $urandom_range(4, 10);
            else
                stall_len = $urandom_range(20, 60);
            if (stall_len > 0)
            begin
                row_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    function automatic gww_pkg::char_item_t mk(logic [1:0] kind, int unsigned w, bit last);
        gww_pkg::char_item_t c;
        c.char_kind = kind;
        c.char_width = gww_pkg::CHAR_W'(w);
        c.last_char = last;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quick_gaps)
            return (r < 90) ? 0 : 1;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 9);
        if (r < 85)
            return 0;
        if (r < 88)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    // The gap comes before the item, so valid is either lowered or given a new
    // item at the edge where the previous one was taken.
    task automatic send_char(gww_pkg::char_item_t c);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            char_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        char_item <= c;
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (char_stall);
        book.note_char(c);
    endtask

    // Waits until every expected row has come and the input register has drained.
    task automatic settle();
        char_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_config(bit r, int unsigned tw);
        cfg_write_en <= 1'b1;
        cfg_index <= gww_pkg::REG_RESTRICT_WIDTH;
        cfg_data <= gww_pkg::CFG_DATA_W'(r);
        @(posedge clk);
        cfg_index <= gww_pkg::REG_TEXT_WIDTH;
        cfg_data <= gww_pkg::CFG_DATA_W'(tw);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        book.set_config(r, tw);
    endtask

    // Words of regular characters separated by spaces, now and then a newline.
    task automatic send_text(int len);
        int left;
        int word;
        logic [1:0] kind;
        int unsigned w;
        left = len;
        while (left > 0)
        begin
            word = $urandom_range(1, 8);
            while (word > 0 && left > 0)
            begin
                kind = (($urandom % 20) == 0) ? KIND_OTHER : gww_pkg::KIND_REGULAR;
                send_char(mk(kind, pick_width(), left == 1));
                word--;
                left--;
            end
            if (left > 0)
            begin
                kind = (($urandom % 7) == 0) ? gww_pkg::KIND_NEWLINE : gww_pkg::KIND_SPACE;
                w = (($urandom % 20) == 0) ? 255 : $urandom_range(0, 6);
                send_char(mk(kind, w, left == 1));
                left--;
            end
        end
    endtask

    task automatic run_phase(int quota);
        int sent;
        int len;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = $urandom_range(4, 30);
                send_text(len);
                sent += len;
            end
            else
            begin
                len = $urandom_range(3, 12);
                repeat (len)
                    send_char(mk(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                                 ($urandom % 10) == 0));
                sent += len;
            end
        end
    endtask

    initial
    begin
        bit phase_restrict[8];
        int unsigned phase_width[8];
        book = new();
        phase_restrict = '{1, 1, 0, 1, 0, 1, 1, 1};
        phase_width = '{40, 0, WIDTH_MAX, 12, 0, WIDTH_MAX, $urandom_range(1, 200), 640};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no width breaking, so only the newline and the end close rows.
        send_char(mk(gww_pkg::KIND_REGULAR, 255, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 255, 0));
        send_char(mk(KIND_OTHER, 255, 0));
        send_char(mk(gww_pkg::KIND_NEWLINE, 0, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 7, 1));
        settle();

        write_config(1'b1, 10);
        // Space break, overfull remainder and an empty final row from one character.
        send_char(mk(gww_pkg::KIND_REGULAR, 3, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 3, 0));
        send_char(mk(gww_pkg::KIND_SPACE, 1, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 15, 1));
        // Leading newline with its width ignored.
        send_char(mk(gww_pkg::KIND_NEWLINE, 255, 0));
        send_char(mk(KIND_OTHER, 0, 1));
        // A single word wider than the row.
        send_char(mk(gww_pkg::KIND_REGULAR, 255, 1));
        send_char(mk(gww_pkg::KIND_SPACE, 255, 0));
        send_char(mk(gww_pkg::KIND_SPACE, 0, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 5, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 6, 0));
        send_char(mk(gww_pkg::KIND_NEWLINE, 9, 1));
        // Exactly at the limit, then one unit past it.
        send_char(mk(gww_pkg::KIND_SPACE, 5, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 5, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 1, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 0, 1));
        settle();

        for (int p = 0; p < 8; p++)
        begin
            write_config(phase_restrict[p], phase_width[p]);
            run_phase(PHASE_ITEMS);
            settle();
        end

        // A wide word under the widest limit, then the limit one below it.
        quick_gaps = 1'b1;
        write_config(1'b1, WIDTH_MAX);
        repeat (LONG_TEXT)
            send_char(mk((($urandom % 10) == 0) ? KIND_OTHER : gww_pkg::KIND_REGULAR,
                         $urandom_range(252, 255), 0));
        settle();
        write_config(1'b1, WIDTH_MAX - 1);
        send_char(mk(gww_pkg::KIND_REGULAR, 0, 0));
        send_char(mk(gww_pkg::KIND_NEWLINE, 0, 0));
        send_char(mk(gww_pkg::KIND_NEWLINE, 0, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 9, 1));
        settle();

        // Short wide words with breaking off, then breaking back on.
        write_config(1'b0, 0);
        for (int k = 0; k < LONG_TEXT; k++)
            send_char(mk(((k % 4) == 3) ? gww_pkg::KIND_SPACE : gww_pkg::KIND_REGULAR,
                         255, 0));
        settle();
        write_config(1'b1, WIDTH_MAX);
        send_char(mk(gww_pkg::KIND_REGULAR, 1, 0));
        send_char(mk(gww_pkg::KIND_REGULAR, 2, 1));
        quick_gaps = 1'b0;
        settle();

        repeat (10) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

[greedy_word_wrap.f]
+incdir+hw/rtl
hw/rtl/gww_pkg.sv
hw/rtl/gww_cfg.sv
hw/rtl/gww_core.sv
hw/rtl/gww_row_queue.sv
hw/rtl/greedy_word_wrap.sv
tb/tb.sv
